FILE: rtl/alwc_pkg.sv
package alwc_pkg;

	localparam logic [1:0] LVL_NORMAL     = 2'd0;
	localparam logic [1:0] LVL_SUSPICIOUS = 2'd1;
	localparam logic [1:0] LVL_ANOMALOUS  = 2'd2;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_SPAN      = 1'b1;

	localparam int SPAN_W = 17;

	typedef struct packed {
		logic [31:0] tstamp;
		logic [1:0]  lvl;
	} entry_t;

	// per-cell control from the head logic
	typedef struct packed {
		logic pop;   // whole row moves one cell toward the head
		logic load;  // this cell takes the new entry
	} cell_ctl_t;

endpackage

FILE: rtl/alwc_classify.sv
module alwc_classify (
	input  logic [31:0] error_score,
	input  logic [31:0] threshold,
	output logic [1:0]  lvl
);

	logic [35:0] err_x10;
	logic [35:0] thr_x9;

	// 0.9 factor done exactly: 10*err <= 9*thr
	assign err_x10 = {1'b0, error_score, 3'b000} + {3'b000, error_score, 1'b0};
	assign thr_x9  = {1'b0, threshold, 3'b000} + {4'b0000, threshold};

	always_comb begin
		if (err_x10 <= thr_x9) begin
			lvl = alwc_pkg::LVL_NORMAL;
		end else if (error_score <= threshold) begin
			lvl = alwc_pkg::LVL_SUSPICIOUS;
		end else begin
			lvl = alwc_pkg::LVL_ANOMALOUS;
		end
	end

endmodule

FILE: rtl/alwc_cell.sv
module alwc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  alwc_pkg::cell_ctl_t ctl,
	input  alwc_pkg::entry_t    new_entry,
	input  alwc_pkg::entry_t    above_entry,
	input  logic                above_valid,
	output alwc_pkg::entry_t    entry,
	output logic                valid
);

	alwc_pkg::entry_t entry_q;
	logic             valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (ctl.pop) begin
			valid_q <= above_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= new_entry;
		end else if (ctl.pop) begin
			entry_q <= above_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

FILE: rtl/anomaly_level_window_counter.sv
// Sliding time window event counter with three-level score classification.
// Input channel (in_valid/in_ready): error_score (unsigned Q16.16) and
// time_seconds. Output channel (out_valid/out_ready): level of that sample and
// the anomalous and suspicious entries held in the window after it.
// Config: cfg_we/cfg_index/cfg_data, index 0 threshold, index 1 span (seconds);
// write only while idle.
// Entries live in a row of RING_DEPTH cells, oldest at cell 0, packed toward
// it. A transfer in pushes the new entry (dropping the oldest if full) in the
// same cycle; then the head cell is checked once per cycle and popped while
// it is too old; with a single head comparator, entries expire one at a time.
// No new input is taken until the final check finds no expired head and the
// result is registered.
// The result sits in an output register: a new input is taken while it waits;
// if the receiver stalls, the next item holds in its final check until the
// register frees, and input stays blocked meanwhile.
// Reset empties all cells and counters and restores threshold 1.0 and a
// 3600 s span; it takes effect at once, no clearing pass.
module anomaly_level_window_counter #(
	parameter int RING_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] error_score,
	input  logic [31:0] time_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  level,
	output logic [7:0]  anomalous_in_window,
	output logic [7:0]  suspicious_in_window
);

	localparam int CW = $clog2(RING_DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_EXPIRE
	} state_t;

	state_t                       state_q;
	logic [31:0]                  thr_q;
	logic [alwc_pkg::SPAN_W-1:0]  span_q;
	logic [31:0]                  now_q;
	logic [1:0]                   lvl_q;
	logic [CW-1:0]                anom_q;
	logic [CW-1:0]                susp_q;
	logic                         out_valid_q;
	logic [1:0]                   out_lvl_q;
	logic [7:0]                   out_anom_q;
	logic [7:0]                   out_susp_q;

	logic [1:0]                   new_lvl;
	alwc_pkg::entry_t             new_entry;
	alwc_pkg::entry_t             cell_entry [RING_DEPTH];
	logic [RING_DEPTH-1:0]        cell_valid;
	alwc_pkg::cell_ctl_t          cell_ctl   [RING_DEPTH];
	logic                         accept;
	logic                         full;
	logic                         expired;
	logic                         pop;
	logic                         finish;
	logic [31:0]                  head_age;
	logic [CW-1:0]                anom_inc, anom_dec, susp_inc, susp_dec;
	logic [1:0]                   head_lvl;

	alwc_classify u_classify (
		.error_score (error_score),
		.threshold   (thr_q),
		.lvl         (new_lvl)
	);

	assign new_entry = '{tstamp: time_seconds, lvl: new_lvl};

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = cell_valid[RING_DEPTH-1];

	assign head_age = now_q - cell_entry[0].tstamp;
	assign expired  = (state_q == ST_EXPIRE) && cell_valid[0]
		&& (now_q >= cell_entry[0].tstamp)
		&& (head_age > {{(32-alwc_pkg::SPAN_W){1'b0}}, span_q});

	// a full row drops its oldest in the push cycle
	assign pop    = (accept && full) || expired;
	assign finish = (state_q == ST_EXPIRE) && !expired && (!out_valid_q || out_ready);

	genvar gi;
	generate
		for (gi = 0; gi < RING_DEPTH; gi++) begin : g_cell
			alwc_pkg::entry_t above_e;
			logic             above_v;
			logic             tail_here;

			if (gi == RING_DEPTH - 1) begin : g_last
				assign above_e = '0;
				assign above_v = 1'b0;
				assign tail_here = pop ? 1'b1 : !cell_valid[gi] && cell_valid[gi-1];
			end else if (gi == 0) begin : g_first
				assign above_e = cell_entry[gi+1];
				assign above_v = cell_valid[gi+1];
				assign tail_here = !cell_valid[gi];
			end else begin : g_mid
				assign above_e = cell_entry[gi+1];
				assign above_v = cell_valid[gi+1];
				assign tail_here = !cell_valid[gi] && cell_valid[gi-1];
			end

			// on a push with drop only the last cell loads; else the first free one
			assign cell_ctl[gi].pop  = pop;
			assign cell_ctl[gi].load = accept && (full ? (gi == RING_DEPTH - 1) : tail_here);

			alwc_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (cell_ctl[gi]),
				.new_entry   (new_entry),
				.above_entry (above_e),
				.above_valid (above_v),
				.entry       (cell_entry[gi]),
				.valid       (cell_valid[gi])
			);
		end
	endgenerate

	assign head_lvl = cell_entry[0].lvl;
	assign anom_inc = CW'(accept && (new_lvl == alwc_pkg::LVL_ANOMALOUS));
	assign susp_inc = CW'(accept && (new_lvl == alwc_pkg::LVL_SUSPICIOUS));
	assign anom_dec = CW'(pop && (head_lvl == alwc_pkg::LVL_ANOMALOUS));
	assign susp_dec = CW'(pop && (head_lvl == alwc_pkg::LVL_SUSPICIOUS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= 32'd65536;
			span_q  <= alwc_pkg::SPAN_W'(3600);
		end else if (cfg_we) begin
			unique case (cfg_index)
				alwc_pkg::REG_THRESHOLD: thr_q  <= cfg_data;
				alwc_pkg::REG_SPAN:      span_q <= cfg_data[alwc_pkg::SPAN_W-1:0];
				default:                 thr_q  <= thr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			anom_q      <= '0;
			susp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			anom_q <= anom_q + anom_inc - anom_dec;
			susp_q <= susp_q + susp_inc - susp_dec;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXPIRE;
					end
				end
				ST_EXPIRE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= time_seconds;
			lvl_q <= new_lvl;
		end
		if (finish) begin
			out_lvl_q  <= lvl_q;
			out_anom_q <= (32'(anom_q) > 32'd255) ? 8'hFF : 8'(anom_q);
			out_susp_q <= (32'(susp_q) > 32'd255) ? 8'hFF : 8'(susp_q);
		end
	end

	assign out_valid            = out_valid_q;
	assign level                = out_lvl_q;
	assign anomalous_in_window  = out_anom_q;
	assign suspicious_in_window = out_susp_q;

endmodule
